// File: sv/bezier_point_evaluator_core_macros.svh
// Assertion macros for the Bezier point evaluator.
// Included by modules that carry concurrent checks; no other dependencies.
`ifndef BEZIER_POINT_EVALUATOR_CORE_MACROS_SVH
`define BEZIER_POINT_EVALUATOR_CORE_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define BPE_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define BPE_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define BPE_ASSERT_IMPL(lbl, clk, rstn, ante, cons)
`define BPE_ASSERT_NEXT(lbl, clk, rstn, ante, cons)

`endif

`endif

// File: sv/bpe_pkg.sv
// Shared constants, types and the binomial coefficient table of the Bezier evaluator.
// No dependencies.
package bpe_pkg;

    localparam int MAX_POINTS = 10;
    localparam int IDX_W      = $clog2(MAX_POINTS);
    localparam int CNT_W      = $clog2(MAX_POINTS + 1);
    localparam int PIDX_W     = 4;
    localparam int CMD_W      = 2;
    localparam int COORD_W    = 12;
    localparam int T_W        = 17;
    localparam int T_FRAC     = 16;
    localparam int Q_FRAC     = 30;
    localparam int P_W        = Q_FRAC + 1;
    localparam int BIN_W      = MAX_POINTS;
    localparam int ACC_W      = 18;
    localparam int OUT_W      = 16;

    localparam logic [T_W-1:0] T_ONE = T_W'(1) << T_FRAC;
    localparam logic [P_W-1:0] P_ONE = P_W'(1) << Q_FRAC;

    localparam logic [CMD_W-1:0] CMD_APPEND  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_REPLACE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_EVAL    = 2'd2;

    typedef logic [MAX_POINTS-1:0][MAX_POINTS-1:0][BIN_W-1:0] binom_tab_t;

    typedef struct packed {
        logic pow_init;
        logic pow_step;
        logic weigh;
        logic rotate;
    } bpe_ctrl_t;

    // Pascal's triangle, row k holds C(k,i)
    function automatic binom_tab_t binom_table();
        binom_tab_t tab;
        tab = '0;
        for (int k = 0; k < MAX_POINTS; k++) begin
            for (int i = 0; i < MAX_POINTS; i++) begin
                if (i == 0) begin
                    tab[k][i] = BIN_W'(1);
                end else if (i <= k) begin
                    tab[k][i] = tab[k-1][i-1] + tab[k-1][i];
                end
            end
        end
        return tab;
    endfunction

    localparam binom_tab_t BINOM = binom_table();

endpackage

// File: sv/bpe_cell.sv
// One control point cell: stores a point, builds its Bernstein power product
// and weight, and rotates point and weight to its neighbor. Uses bpe_pkg.
module bpe_cell (
    input  logic                                     aclk,
    input  bpe_pkg::bpe_ctrl_t                       ctrl,
    input  logic                                     wr_en,
    input  logic signed [bpe_pkg::COORD_W-1:0]       wr_x,
    input  logic signed [bpe_pkg::COORD_W-1:0]       wr_y,
    input  logic [bpe_pkg::IDX_W-1:0]                cell_idx,
    input  logic [bpe_pkg::IDX_W-1:0]                step,
    input  logic [bpe_pkg::T_W-1:0]                  t_val,
    input  logic [bpe_pkg::T_W-1:0]                  u_val,
    input  logic [bpe_pkg::BIN_W-1:0]                coef,
    input  logic signed [bpe_pkg::COORD_W-1:0]       nb_x,
    input  logic signed [bpe_pkg::COORD_W-1:0]       nb_y,
    input  logic [bpe_pkg::P_W-1:0]                  nb_w,
    output logic signed [bpe_pkg::COORD_W-1:0]       x_out,
    output logic signed [bpe_pkg::COORD_W-1:0]       y_out,
    output logic [bpe_pkg::P_W-1:0]                  w_out
);

    localparam int POW_PW = bpe_pkg::P_W + bpe_pkg::T_W;
    localparam int WGT_PW = bpe_pkg::BIN_W + bpe_pkg::P_W;

    logic signed [bpe_pkg::COORD_W-1:0] x_reg, x_next;
    logic signed [bpe_pkg::COORD_W-1:0] y_reg, y_next;
    logic [bpe_pkg::P_W-1:0]            p_reg, p_next;
    logic [bpe_pkg::P_W-1:0]            w_reg, w_next;
    logic [bpe_pkg::T_W-1:0]            mult_sel;
    logic [POW_PW-1:0]                  pow_prod;
    logic [WGT_PW-1:0]                  w_prod;

    // t for the first cell_idx steps, then u
    assign mult_sel = (step < cell_idx) ? t_val : u_val;
    assign pow_prod = POW_PW'(p_reg) * POW_PW'(mult_sel);
    // weight never exceeds 2^30, so the low bits hold it exactly
    assign w_prod   = WGT_PW'(coef) * WGT_PW'(p_reg);

    always_comb begin
        x_next = x_reg;
        y_next = y_reg;
        p_next = p_reg;
        w_next = w_reg;
        if (wr_en) begin
            x_next = wr_x;
            y_next = wr_y;
        end else if (ctrl.rotate) begin
            x_next = nb_x;
            y_next = nb_y;
        end
        if (ctrl.pow_init) begin
            p_next = bpe_pkg::P_ONE;
        end else if (ctrl.pow_step) begin
            p_next = pow_prod[bpe_pkg::T_FRAC +: bpe_pkg::P_W];
        end
        if (ctrl.weigh) begin
            w_next = w_prod[bpe_pkg::P_W-1:0];
        end else if (ctrl.rotate) begin
            w_next = nb_w;
        end
    end

    always_ff @(posedge aclk) begin
        x_reg <= x_next;
        y_reg <= y_next;
        p_reg <= p_next;
        w_reg <= w_next;
    end

    assign x_out = x_reg;
    assign y_out = y_reg;
    assign w_out = w_reg;

endmodule

// File: sv/bpe_accum.sv
// Running Bernstein sum for one coordinate: adds weight*coord in Q30 and
// truncates toward zero after every term. Uses bpe_pkg.
module bpe_accum (
    input  logic                                   aclk,
    input  logic                                   clear,
    input  logic                                   acc_en,
    input  logic [bpe_pkg::P_W-1:0]                weight,
    input  logic signed [bpe_pkg::COORD_W-1:0]     coord,
    output logic signed [bpe_pkg::ACC_W-1:0]       sum
);

    localparam int PROD_W = bpe_pkg::P_W + 1 + bpe_pkg::COORD_W;
    localparam int F_W    = bpe_pkg::ACC_W + bpe_pkg::Q_FRAC;

    logic signed [bpe_pkg::ACC_W-1:0] sum_reg, sum_next;
    logic signed [PROD_W-1:0]         prod;
    logic signed [F_W-1:0]            full;
    logic signed [bpe_pkg::ACC_W-1:0] floor_q;
    logic                             round_up;

    assign prod     = $signed({1'b0, weight}) * coord;
    assign full     = $signed({sum_reg, {bpe_pkg::Q_FRAC{1'b0}}}) + F_W'(prod);
    assign floor_q  = full[F_W-1:bpe_pkg::Q_FRAC];
    // negative with a fraction: floor is one below the truncated value
    assign round_up = full[F_W-1] && (|full[bpe_pkg::Q_FRAC-1:0]);

    always_comb begin
        sum_next = sum_reg;
        if (clear) begin
            sum_next = '0;
        end else if (acc_en) begin
            sum_next = floor_q + bpe_pkg::ACC_W'(round_up);
        end
    end

    always_ff @(posedge aclk) begin
        sum_reg <= sum_next;
    end

    assign sum = sum_reg;

endmodule

// File: sv/bezier_point_evaluator_core.sv
// Bezier point evaluator top: command decode, sequencer, ring of point cells, two accumulators.
// Append and replace are taken in idle and may follow back to back.
// Evaluate with n stored points: power steps (if n > 1), weigh, a full ring rotation, flush; the
// result is registered as the input turns ready again; both wait while the output stalls.
// aresetn (sync, active low) clears point count, sequencer and output valid; points hold.
`include "bezier_point_evaluator_core_macros.svh"

module bezier_point_evaluator_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [3:0] point_index, [15:4] coord_x, [27:16] coord_y, [44:28] param_t, [47:45] zero
    input  logic [47:0] s_axis_tdata,
    // [1:0] command
    input  logic [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [15:0] curve_x, [31:16] curve_y
    output logic [31:0] m_axis_tdata
);

    // sequencer states
    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_POWER  = 3'd1;
    localparam logic [2:0] ST_WEIGH  = 3'd2;
    localparam logic [2:0] ST_ROTATE = 3'd3;
    localparam logic [2:0] ST_FLUSH  = 3'd4;

    // input field offsets in tdata
    localparam int OFS_IDX = 0;
    localparam int OFS_X   = OFS_IDX + bpe_pkg::PIDX_W;
    localparam int OFS_Y   = OFS_X + bpe_pkg::COORD_W;
    localparam int OFS_T   = OFS_Y + bpe_pkg::COORD_W;

    localparam int NP  = bpe_pkg::MAX_POINTS;
    localparam int IW  = bpe_pkg::IDX_W;
    localparam int CW  = bpe_pkg::CNT_W;

    logic [2:0]                         state_reg, state_next;
    logic [CW-1:0]                      count_reg, count_next;
    logic [IW-1:0]                      cnt_reg, cnt_next;
    logic [bpe_pkg::T_W-1:0]            t_reg, t_next;
    logic [bpe_pkg::T_W-1:0]            u_reg, u_next;
    logic                               m_valid_reg, m_valid_next;
    logic [bpe_pkg::OUT_W-1:0]          m_x_reg, m_x_next;
    logic [bpe_pkg::OUT_W-1:0]          m_y_reg, m_y_next;

    // input decode
    logic                               s_fire;
    logic [bpe_pkg::CMD_W-1:0]          in_cmd;
    logic [bpe_pkg::PIDX_W-1:0]         in_idx;
    logic signed [bpe_pkg::COORD_W-1:0] in_x;
    logic signed [bpe_pkg::COORD_W-1:0] in_y;
    logic [bpe_pkg::T_W-1:0]            in_t;
    logic [bpe_pkg::T_W-1:0]            t_sat;

    logic                               do_append;
    logic                               do_replace;
    logic                               do_eval;
    logic [IW-1:0]                      wr_addr;
    logic [IW-1:0]                      row_sel;
    logic                               out_free;
    logic                               flush_fire;
    logic                               acc_clear;
    logic                               acc_en;
    bpe_pkg::bpe_ctrl_t                 ctrl;

    // cell ring wiring; cell k hands to cell k-1, cell 0 feeds the accumulators
    logic signed [bpe_pkg::COORD_W-1:0] cx [NP];
    logic signed [bpe_pkg::COORD_W-1:0] cy [NP];
    logic [bpe_pkg::P_W-1:0]            cw [NP];
    logic signed [bpe_pkg::ACC_W-1:0]   sum_x;
    logic signed [bpe_pkg::ACC_W-1:0]   sum_y;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign s_fire        = s_axis_tvalid && s_axis_tready;

    assign in_cmd = s_axis_tuser;
    assign in_idx = s_axis_tdata[OFS_IDX +: bpe_pkg::PIDX_W];
    assign in_x   = s_axis_tdata[OFS_X +: bpe_pkg::COORD_W];
    assign in_y   = s_axis_tdata[OFS_Y +: bpe_pkg::COORD_W];
    assign in_t   = s_axis_tdata[OFS_T +: bpe_pkg::T_W];
    // t above 1.0 saturates
    assign t_sat  = (in_t > bpe_pkg::T_ONE) ? bpe_pkg::T_ONE : in_t;

    // append past capacity and replace beyond the count are dropped
    assign do_append  = s_fire && (in_cmd == bpe_pkg::CMD_APPEND)
                        && (count_reg < CW'(NP));
    assign do_replace = s_fire && (in_cmd == bpe_pkg::CMD_REPLACE)
                        && ({1'b0, in_idx} < (bpe_pkg::PIDX_W + 1)'(count_reg));
    assign do_eval    = s_fire && (in_cmd == bpe_pkg::CMD_EVAL);
    assign wr_addr    = do_append ? count_reg[IW-1:0] : in_idx[IW-1:0];

    // binomial row n-1; row 0 when empty (nothing is summed then)
    assign row_sel    = (count_reg == '0) ? '0 : IW'(count_reg - CW'(1));
    assign out_free   = !m_valid_reg || m_axis_tready;
    assign flush_fire = (state_reg == ST_FLUSH) && out_free;

    always_comb begin
        ctrl.pow_init = do_eval;
        ctrl.pow_step = (state_reg == ST_POWER);
        ctrl.weigh    = (state_reg == ST_WEIGH);
        ctrl.rotate   = (state_reg == ST_ROTATE);
    end

    assign acc_clear = do_eval;
    // cell 0 holds point cnt during rotation
    assign acc_en    = (state_reg == ST_ROTATE) && (CW'(cnt_reg) < count_reg);

    always_comb begin
        state_next   = state_reg;
        count_next   = count_reg;
        cnt_next     = cnt_reg;
        t_next       = t_reg;
        u_next       = u_reg;
        m_valid_next = m_valid_reg;
        m_x_next     = m_x_reg;
        m_y_next     = m_y_reg;

        if (m_valid_reg && m_axis_tready) begin
            m_valid_next = 1'b0;
        end
        if (do_append) begin
            count_next = count_reg + CW'(1);
        end

        case (state_reg)
            ST_IDLE: begin
                if (do_eval) begin
                    t_next     = t_sat;
                    u_next     = bpe_pkg::T_ONE - t_sat;
                    cnt_next   = '0;
                    state_next = (count_reg > CW'(1)) ? ST_POWER : ST_WEIGH;
                end
            end
            ST_POWER: begin
                // n-1 power steps, cnt runs 0 .. n-2
                if ((CW + 1)'(cnt_reg) + (CW + 1)'(2) == (CW + 1)'(count_reg)) begin
                    cnt_next   = '0;
                    state_next = ST_WEIGH;
                end else begin
                    cnt_next = cnt_reg + IW'(1);
                end
            end
            ST_WEIGH: begin
                cnt_next   = '0;
                state_next = ST_ROTATE;
            end
            ST_ROTATE: begin
                // full turn of the ring so every point returns to its own cell
                if (cnt_reg == IW'(NP - 1)) begin
                    cnt_next   = '0;
                    state_next = ST_FLUSH;
                end else begin
                    cnt_next = cnt_reg + IW'(1);
                end
            end
            ST_FLUSH: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_x_next     = sum_x[bpe_pkg::OUT_W-1:0];
                    m_y_next     = sum_y[bpe_pkg::OUT_W-1:0];
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        t_reg   <= t_next;
        u_reg   <= u_next;
        m_x_reg <= m_x_next;
        m_y_reg <= m_y_next;
    end

    genvar k;
    generate
        for (k = 0; k < NP; k++) begin : g_cell
            bpe_cell u_cell (
                .aclk     (aclk),
                .ctrl     (ctrl),
                .wr_en    ((do_append || do_replace) && (wr_addr == IW'(k))),
                .wr_x     (in_x),
                .wr_y     (in_y),
                .cell_idx (IW'(k)),
                .step     (cnt_reg),
                .t_val    (t_reg),
                .u_val    (u_reg),
                .coef     (bpe_pkg::BINOM[row_sel][k]),
                .nb_x     (cx[(k + 1) % NP]),
                .nb_y     (cy[(k + 1) % NP]),
                .nb_w     (cw[(k + 1) % NP]),
                .x_out    (cx[k]),
                .y_out    (cy[k]),
                .w_out    (cw[k])
            );
        end
    endgenerate

    bpe_accum u_acc_x (
        .aclk   (aclk),
        .clear  (acc_clear),
        .acc_en (acc_en),
        .weight (cw[0]),
        .coord  (cx[0]),
        .sum    (sum_x)
    );

    bpe_accum u_acc_y (
        .aclk   (aclk),
        .clear  (acc_clear),
        .acc_en (acc_en),
        .weight (cw[0]),
        .coord  (cy[0]),
        .sum    (sum_y)
    );

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {m_y_reg, m_x_reg};

    // an accepted append below capacity grows the count by one
    `BPE_ASSERT_NEXT(a_count_grows, aclk, aresetn, do_append, count_reg == $past(count_reg) + CW'(1))
    // nothing but an append moves the count
    `BPE_ASSERT_NEXT(a_count_holds, aclk, aresetn, !do_append, count_reg == $past(count_reg))
    // power steps only run with two or more points
    `BPE_ASSERT_IMPL(a_power_needs_two, aclk, aresetn, state_reg == ST_POWER, count_reg > CW'(1))
    // a finished sum lands in a free output register and frees the input side
    `BPE_ASSERT_NEXT(a_flush_out, aclk, aresetn, flush_fire, m_valid_reg && (state_reg == ST_IDLE))

endmodule

// File: sim/bpe_curve_checker.sv
// Watches both stream channels of the Bezier point evaluator and checks every result.
// Keeps its own copy of the control points and predicts each evaluated curve point.
// Depends on bpe_pkg for the command codes and the point capacity.
module bpe_curve_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,
    input  logic [1:0]  s_axis_tuser,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [31:0] m_axis_tdata,
    output int          mismatch_count,
    output int          awaited_count
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint Q_UNIT = longint'(1) << bpe_pkg::Q_FRAC;

    typedef struct {
        logic signed [15:0] x;
        logic signed [15:0] y;
    } curve_pt_t;

    curve_pt_t          awaited_pts[$];
    logic signed [11:0] knot_x[bpe_pkg::MAX_POINTS];
    logic signed [11:0] knot_y[bpe_pkg::MAX_POINTS];
    int unsigned        knot_count;

    // Bernstein sum over the stored knots; sums truncated toward zero after each term
    function automatic curve_pt_t curve_at(input logic [16:0] t_raw);
        longint unsigned t_q, u_q, pw, coef;
        longint          w, sx, sy;
        int              n;
        curve_pt_t       pt;
        t_q  = (t_raw > bpe_pkg::T_ONE) ? longint'(bpe_pkg::T_ONE) : longint'(t_raw);
        u_q  = longint'(bpe_pkg::T_ONE) - t_q;
        n    = int'(knot_count);
        coef = 1;
        sx   = 0;
        sy   = 0;
        for (int i = 0; i < n; i++) begin
            pw = longint'(1) << bpe_pkg::Q_FRAC;
            for (int j = 0; j < i; j++) pw = (pw * t_q) >> bpe_pkg::T_FRAC;
            for (int j = 0; j < n - 1 - i; j++) pw = (pw * u_q) >> bpe_pkg::T_FRAC;
            w  = longint'(coef * pw);
            sx = (sx * Q_UNIT + w * longint'(knot_x[i])) / Q_UNIT;
            sy = (sy * Q_UNIT + w * longint'(knot_y[i])) / Q_UNIT;
            coef = coef * longint'(n - 1 - i) / longint'(i + 1);
        end
        pt.x = sx[15:0];
        pt.y = sy[15:0];
        return pt;
    endfunction

    always @(posedge aclk) begin : watch
        curve_pt_t          got;
        curve_pt_t          want;
        logic [3:0]         slot;
        logic signed [11:0] px;
        logic signed [11:0] py;
        if (!aresetn) begin
            knot_count     = 0;
            mismatch_count = 0;
        end else begin
            // results first: a transfer on the input side this edge cannot be answered yet
            if (m_axis_tvalid && m_axis_tready) begin
                got.x = m_axis_tdata[15:0];
                got.y = m_axis_tdata[31:16];
                if (awaited_pts.size() == 0) begin
                    $error("curve point x=%0d y=%0d with none awaited", got.x, got.y);
                    mismatch_count++;
                end else begin
                    want = awaited_pts.pop_front();
                    if (got.x !== want.x) begin
                        $error("curve_x: expected %0d, got %0d", want.x, got.x);
                        mismatch_count++;
                    end
                    if (got.y !== want.y) begin
                        $error("curve_y: expected %0d, got %0d", want.y, got.y);
                        mismatch_count++;
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                slot = s_axis_tdata[3:0];
                px   = s_axis_tdata[15:4];
                py   = s_axis_tdata[27:16];
                case (s_axis_tuser)
                    bpe_pkg::CMD_APPEND: begin
                        if (knot_count < bpe_pkg::MAX_POINTS) begin
                            knot_x[knot_count] = px;
                            knot_y[knot_count] = py;
                            knot_count++;
                        end
                    end
                    bpe_pkg::CMD_REPLACE: begin
                        if (slot < knot_count) begin
                            knot_x[slot] = px;
                            knot_y[slot] = py;
                        end
                    end
                    bpe_pkg::CMD_EVAL: awaited_pts.push_back(curve_at(s_axis_tdata[44:28]));
                    default: ;
                endcase
            end
        end
        awaited_count <= awaited_pts.size();
    end

endmodule

// File: sim/bezier_point_evaluator_core_tb.sv
// Testbench top for the Bezier point evaluator: clock, reset, command stimulus, verdict.
// Depends on bpe_pkg, the block itself and bpe_curve_checker for prediction and compare.
module bezier_point_evaluator_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    // command code the block must ignore
    localparam logic [bpe_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;
    // random items that do real work (ignored noise not counted)
    localparam int RAND_WORK = 900;
    // evaluation latency with a full ring, plus margin
    localparam int DRAIN_CYCLES = 4 * (2 * bpe_pkg::MAX_POINTS + 2);

    logic        aclk          = 1'b0;
    logic        aresetn       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata  = '0;
    logic [1:0]  s_axis_tuser  = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;

    int mismatch_count;
    int awaited_count;

    // idle odds in percent, per phase
    int src_idle   = 0;
    int sink_stall = 0;

    bezier_point_evaluator_core DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    bpe_curve_checker u_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_axis_tvalid  (s_axis_tvalid),
        .s_axis_tready  (s_axis_tready),
        .s_axis_tdata   (s_axis_tdata),
        .s_axis_tuser   (s_axis_tuser),
        .m_axis_tvalid  (m_axis_tvalid),
        .m_axis_tready  (m_axis_tready),
        .m_axis_tdata   (m_axis_tdata),
        .mismatch_count (mismatch_count),
        .awaited_count  (awaited_count)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Slowest correct run is roughly 1150 items plus sender gaps and sink stalls;
    // 5 ms leaves a wide margin.
    initial begin
        #5_000_000;
        $display("TB_ERROR");
        $finish;
    end

    // Result side backpressure, redrawn every cycle
    always @(posedge aclk) begin
        m_axis_tready <= ($urandom_range(0, 99) >= sink_stall);
    end

    // One command transfer. Idle cycles come first, with tvalid low, so that tvalid
    // stays high across back-to-back transfers without a second assignment in a step.
    task automatic send_cmd(input logic [1:0] cmd, input logic [3:0] slot,
                            input logic [11:0] px, input logic [11:0] py,
                            input logic [16:0] t_q);
        while ($urandom_range(0, 99) < src_idle) begin
            s_axis_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= {3'b000, t_q, py, px, slot};
        do @(posedge aclk); while (!s_axis_tready);
    endtask

    // t mostly inside [0, 1.0]; some exact ends and some above 1.0 (saturation)
    function automatic logic [16:0] pick_t();
        int sel;
        sel = $urandom_range(0, 9);
        case (sel)
            0:       return 17'd0;
            1:       return bpe_pkg::T_ONE;
            2:       return 17'($urandom_range(bpe_pkg::T_ONE + 1, 17'h1FFFF));
            default: return 17'($urandom_range(0, bpe_pkg::T_ONE));
        endcase
    endfunction

    initial begin : stimulus
        int work_done;
        int roll;
        int phase;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: empty set, coordinate extremes, every point count, saturated t,
        // append when full, out-of-range replace, unused command.
        send_cmd(bpe_pkg::CMD_EVAL, 4'd0, 12'd0, 12'd0, 17'd0);
        send_cmd(bpe_pkg::CMD_EVAL, 4'hF, 12'hFFF, 12'hFFF, 17'h1FFFF);
        send_cmd(bpe_pkg::CMD_APPEND, 4'd0, 12'h7FF, 12'h800, 17'd0);
        send_cmd(bpe_pkg::CMD_EVAL, 4'd0, 12'd0, 12'd0, 17'h1FFFF);
        send_cmd(bpe_pkg::CMD_APPEND, 4'd0, 12'h800, 12'h7FF, 17'd0);
        send_cmd(bpe_pkg::CMD_EVAL, 4'd0, 12'd0, 12'd0, bpe_pkg::T_ONE);
        for (int k = 3; k <= bpe_pkg::MAX_POINTS; k++) begin
            send_cmd(bpe_pkg::CMD_APPEND, 4'($urandom), 12'($urandom), 12'($urandom),
                     17'($urandom));
            send_cmd(bpe_pkg::CMD_EVAL, 4'd0, 12'd0, 12'd0, pick_t());
        end
        // ring full: this append must be dropped
        send_cmd(bpe_pkg::CMD_APPEND, 4'd0, 12'h7FF, 12'h7FF, 17'd0);
        send_cmd(bpe_pkg::CMD_EVAL, 4'd0, 12'd0, 12'd0, 17'd40000);
        send_cmd(bpe_pkg::CMD_REPLACE, 4'(bpe_pkg::MAX_POINTS), 12'h7FF, 12'h7FF, 17'd0);
        send_cmd(CMD_UNUSED, 4'd0, 12'h7FF, 12'h7FF, bpe_pkg::T_ONE);
        send_cmd(bpe_pkg::CMD_REPLACE, 4'(bpe_pkg::MAX_POINTS - 1), 12'h7FF, 12'h7FF, 17'd0);
        send_cmd(bpe_pkg::CMD_REPLACE, 4'd0, 12'h800, 12'h800, 17'd0);
        send_cmd(bpe_pkg::CMD_EVAL, 4'd0, 12'd0, 12'd0, 17'd1);

        // Random: evaluations and in-range replaces, with some ignored noise mixed in.
        // Four handshake phases: free flow, sparse sender, stalling sink, both.
        work_done = 0;
        while (work_done < RAND_WORK) begin
            phase = work_done * 4 / RAND_WORK;
            case (phase)
                0:       begin src_idle = 0;  sink_stall = 0;  end
                1:       begin src_idle = 78; sink_stall = 0;  end
                2:       begin src_idle = 0;  sink_stall = 78; end
                default: begin src_idle = 27; sink_stall = 27; end
            endcase
            roll = $urandom_range(0, 99);
            if (roll < 45) begin
                send_cmd(bpe_pkg::CMD_EVAL, 4'($urandom), 12'($urandom), 12'($urandom),
                         pick_t());
                work_done++;
            end else if (roll < 80) begin
                send_cmd(bpe_pkg::CMD_REPLACE, 4'($urandom_range(0, bpe_pkg::MAX_POINTS - 1)),
                         12'($urandom), 12'($urandom), 17'($urandom));
                work_done++;
            end else if (roll < 87) begin
                send_cmd(bpe_pkg::CMD_APPEND, 4'($urandom), 12'($urandom), 12'($urandom),
                         17'($urandom));
            end else if (roll < 94) begin
                send_cmd(bpe_pkg::CMD_REPLACE, 4'($urandom_range(bpe_pkg::MAX_POINTS, 15)),
                         12'($urandom), 12'($urandom), 17'($urandom));
            end else begin
                send_cmd(CMD_UNUSED, 4'($urandom), 12'($urandom), 12'($urandom),
                         17'($urandom));
            end
        end
        s_axis_tvalid <= 1'b0;

        // drain outstanding results, then give stray ones a chance to show up
        @(posedge aclk);
        while (awaited_count != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

// File: bezier_point_evaluator_core.f
+incdir+sv
sv/bpe_pkg.sv
sv/bpe_cell.sv
sv/bpe_accum.sv
sv/bezier_point_evaluator_core.sv
sim/bpe_curve_checker.sv
sim/bezier_point_evaluator_core_tb.sv
